// ===== design/kpsd_pkg.sv =====
// shared constants for the keypad scan and debounce block
package kpsd_pkg;

    localparam int COLUMNS   = 4;
    localparam int ROWS      = 4;
    localparam int KEYS      = COLUMNS * ROWS;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int KEY_W     = $clog2(KEYS);
    localparam int CNT_W     = 3;
    localparam int LIMIT_RST = 3;

    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [ROWS-1:0]  t_rows;

    localparam t_col LAST_COL = t_col'(COLUMNS - 1);

endpackage

// ===== design/kpsd_if.sv =====
// request channels of the keypad scan and debounce block

interface kpsd_row_if;
    logic                 valid;
    logic                 ready;
    kpsd_pkg::t_rows      row_levels;

    modport source (output valid, output row_levels, input ready);
    modport sink   (input valid, input row_levels, output ready);
endinterface

interface kpsd_key_if;
    logic                 valid;
    logic                 ready;
    kpsd_pkg::t_col       scanned_column;
    kpsd_pkg::t_rows      green_rows;
    kpsd_pkg::t_rows      press_rows;
    logic                 key_down;
    kpsd_pkg::t_key       key_number;

    modport source (output valid, output scanned_column, output green_rows,
                    output press_rows, output key_down, output key_number,
                    input ready);
    modport sink   (input valid, input scanned_column, input green_rows,
                    input press_rows, input key_down, input key_number,
                    output ready);
endinterface

interface kpsd_cfg_if;
    logic                 valid;
    logic                 ready;
    kpsd_pkg::t_cnt       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/keypad_scan_debounce_select_core.sv =====
// keypad matrix scanner with saturating debounce counters and one-hot led select
//
// Each request is one scan tick holding the active-low row levels of the column
// currently selected; the block answers with that column's number, its led
// colors as they stood before the tick, the rows whose debounce counters reached
// the limit on this tick, and the key number of the highest such row. A newly
// pressed key becomes the only lit led. Throughput is one request per clock:
// a request is registered in an input stage, then the counter update for the
// selected column and the result are computed together and loaded into the
// output register. The input stage and output register move together, so the
// block keeps accepting as long as the output side takes results. The debounce
// limit write channel is always ready and should only be written while no
// request is in flight.
module keypad_scan_debounce_select_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kpsd_cfg_if.sink    i_cfg,
    kpsd_row_if.sink    i_row,
    kpsd_key_if.source  o_key
);

    kpsd_pkg::t_cnt        r_limit;
    kpsd_pkg::t_col        r_col;
    kpsd_pkg::t_cnt        r_cnt [kpsd_pkg::ROWS][kpsd_pkg::COLUMNS];
    logic                  r_led_on;
    kpsd_pkg::t_key        r_led_key;

    logic                  r_s1_valid;
    kpsd_pkg::t_rows       r_s1_levels;

    logic                  r_out_valid;
    kpsd_pkg::t_col        r_out_col;
    kpsd_pkg::t_rows       r_out_green;
    kpsd_pkg::t_rows       r_out_press;
    logic                  r_out_down;
    kpsd_pkg::t_key        r_out_key;

    logic                  s1_advance;
    kpsd_pkg::t_cnt        n_cnt [kpsd_pkg::ROWS];
    kpsd_pkg::t_rows       n_press;
    kpsd_pkg::t_rows       green;
    logic                  n_any;
    kpsd_pkg::t_key        n_key;
    kpsd_pkg::t_key        col_base;
    kpsd_pkg::t_col        n_col;

    assign i_cfg.ready = 1'b1;
    assign s1_advance  = r_s1_valid && (!r_out_valid || o_key.ready);
    assign i_row.ready = !r_s1_valid || s1_advance;

    assign col_base = kpsd_pkg::t_key'(r_col) * kpsd_pkg::t_key'(kpsd_pkg::ROWS);
    assign n_col    = (r_col == kpsd_pkg::LAST_COL) ? '0 : r_col + 1'b1;

    always_comb begin
        n_press = '0;
        n_any   = 1'b0;
        n_key   = '0;
        green   = '0;
        for (int r = 0; r < kpsd_pkg::ROWS; r++) begin
            // only one led is ever lit, stored as its key number
            green[r] = r_led_on &&
                       (r_led_key == col_base + kpsd_pkg::t_key'(r));
            n_cnt[r] = r_cnt[r][r_col];
            if (!r_s1_levels[r]) begin
                if (r_cnt[r][r_col] < r_limit) begin
                    n_cnt[r] = r_cnt[r][r_col] + 1'b1;
                    if (n_cnt[r] == r_limit) begin
                        n_press[r] = 1'b1;
                        n_any      = 1'b1;
                        // later rows override, so the highest row wins
                        n_key      = col_base + kpsd_pkg::t_key'(r);
                    end
                end
            end else if (r_cnt[r][r_col] != '0) begin
                n_cnt[r] = r_cnt[r][r_col] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= kpsd_pkg::t_cnt'(kpsd_pkg::LIMIT_RST);
            r_col       <= '0;
            r_led_on    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < kpsd_pkg::ROWS; r++) begin
                for (int c = 0; c < kpsd_pkg::COLUMNS; c++) begin
                    r_cnt[r][c] <= '0;
                end
            end
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
            if (i_row.ready) begin
                r_s1_valid <= i_row.valid;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_col       <= n_col;
                for (int r = 0; r < kpsd_pkg::ROWS; r++) begin
                    r_cnt[r][r_col] <= n_cnt[r];
                end
                if (n_any) begin
                    r_led_on <= 1'b1;
                end
            end else if (o_key.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_row.valid && i_row.ready) begin
            r_s1_levels <= i_row.row_levels;
        end
        if (s1_advance) begin
            r_out_col   <= r_col;
            r_out_green <= green;
            r_out_press <= n_press;
            r_out_down  <= n_any;
            r_out_key   <= n_key;
            if (n_any) begin
                r_led_key <= n_key;
            end
        end
    end

    assign o_key.valid          = r_out_valid;
    assign o_key.scanned_column = r_out_col;
    assign o_key.green_rows     = r_out_green;
    assign o_key.press_rows     = r_out_press;
    assign o_key.key_down       = r_out_down;
    assign o_key.key_number     = r_out_key;

    a_down_has_press : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_down == (r_out_press != '0)))
        else $error("key_down disagrees with press_rows");

    a_idle_key_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_down) |-> (r_out_key == '0))
        else $error("key_number set without a press");

    a_col_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> (r_col == $past(n_col)) && r_out_valid)
        else $error("column did not advance with a result");

    a_led_follows_press : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && n_any) |=> r_led_on && (r_led_key == r_out_key))
        else $error("lit led does not match the reported key");

    a_green_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out_green))
        else $error("more than one green led in a column");

    a_stall_holds_col : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_advance |=> $stable(r_col))
        else $error("column moved without a result");

endmodule

// ===== test/tb_keypad_scan_debounce_select_core.sv =====
// testbench for the keypad scan and debounce block: scoreboard class, drivers and checks
`timescale 1ns / 1ps

module tb_keypad_scan_debounce_select_core;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 175;

    typedef struct packed {
        kpsd_pkg::t_col  scanned_column;
        kpsd_pkg::t_rows green_rows;
        kpsd_pkg::t_rows press_rows;
        logic            key_down;
        kpsd_pkg::t_key  key_number;
    } t_key_result;

    // mirrors the counters, leds and column of the block and queues the results it predicts
    class key_scoreboard;
        kpsd_pkg::t_cnt            limit;
        kpsd_pkg::t_col            column;
        kpsd_pkg::t_cnt            counts[kpsd_pkg::KEYS];
        logic [kpsd_pkg::KEYS-1:0] leds;
        t_key_result               pending_keys[$];
        int                        errors;

        function new();
            limit  = kpsd_pkg::t_cnt'(kpsd_pkg::LIMIT_RST);
            column = '0;
            foreach (counts[k]) counts[k] = '0;
            leds   = '0;
            errors = 0;
        endfunction

        function void set_limit(kpsd_pkg::t_cnt value);
            limit = value;
        endfunction

        function void note_scan(kpsd_pkg::t_rows levels);
            t_key_result res;
            int          idx;
            res = '0;
            res.scanned_column = column;
            for (int r = 0; r < kpsd_pkg::ROWS; r++) begin
                res.green_rows[r] = leds[int'(column) * kpsd_pkg::ROWS + r];
            end
            for (int r = 0; r < kpsd_pkg::ROWS; r++) begin
                idx = int'(column) * kpsd_pkg::ROWS + r;
                if (!levels[r]) begin
                    if (counts[idx] < limit) begin
                        counts[idx] = counts[idx] + 1'b1;
                        // a new press makes this key the only lit one; higher rows win
                        if (counts[idx] == limit) begin
                            leds = '0;
                            leds[idx] = 1'b1;
                            res.press_rows[r] = 1'b1;
                            res.key_down = 1'b1;
                            res.key_number = kpsd_pkg::t_key'(idx);
                        end
                    end
                end else if (counts[idx] != '0) begin
                    counts[idx] = counts[idx] - 1'b1;
                end
            end
            column = (column == kpsd_pkg::LAST_COL) ? '0 : column + 1'b1;
            pending_keys.push_back(res);
        endfunction

        function void compare_field(string name, int exp_val, int got_val);
            if (exp_val != got_val) begin
                errors++;
                $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
            end
        endfunction

        function void check_key(t_key_result got);
            t_key_result want;
            if (pending_keys.size() == 0) begin
                errors++;
                $display("%0t: result expected none got %h", $time, got);
            end else begin
                want = pending_keys.pop_front();
                compare_field("scanned_column", want.scanned_column, got.scanned_column);
                compare_field("green_rows", want.green_rows, got.green_rows);
                compare_field("press_rows", want.press_rows, got.press_rows);
                compare_field("key_down", want.key_down, got.key_down);
                compare_field("key_number", want.key_number, got.key_number);
            end
        endfunction

        function int pending();
            return pending_keys.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    kpsd_cfg_if cfg_if ();
    kpsd_row_if row_if ();
    kpsd_key_if key_if ();

    keypad_scan_debounce_select_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_row   (row_if.sink),
        .o_key   (key_if.source)
    );

    key_scoreboard sb = new();

    int              send_idle_pct = 0;
    int              key_stall_pct = 0;
    int              stall_cycles  = 0;
    int              scan_col      = 0;
    kpsd_pkg::t_rows held_keys[kpsd_pkg::COLUMNS];

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        key_if.ready <= ($urandom_range(99) >= key_stall_pct);
    end

    // observe every handshake and keep the no-progress count for the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.set_limit(cfg_if.data);
            if (row_if.valid && row_if.ready) sb.note_scan(row_if.row_levels);
            if (key_if.valid && key_if.ready) begin
                sb.check_key({key_if.scanned_column, key_if.green_rows, key_if.press_rows,
                              key_if.key_down, key_if.key_number});
            end
        end
        if ((cfg_if.valid && cfg_if.ready) || (row_if.valid && row_if.ready) ||
            (key_if.valid && key_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAIL keypad_scan_debounce_select_core");
        $finish;
    end

    task automatic send_scan(input kpsd_pkg::t_rows levels);
        while ($urandom_range(99) < send_idle_pct) begin
            row_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        row_if.valid      <= 1'b1;
        row_if.row_levels <= levels;
        @(posedge i_clk);
        while (!row_if.ready) @(posedge i_clk);
        scan_col = (scan_col + 1) % kpsd_pkg::COLUMNS;
    endtask

    // lower valid and wait for every queued result before touching the limit
    task automatic drain_scans();
        row_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input kpsd_pkg::t_cnt value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // mostly keys held over several visits of their column, with bounce and noise
    function automatic kpsd_pkg::t_rows next_levels(input int col);
        kpsd_pkg::t_rows levels;
        if ($urandom_range(99) < 12) begin
            levels = kpsd_pkg::t_rows'($urandom);
        end else begin
            if ($urandom_range(99) < 15) begin
                held_keys[col][$urandom_range(kpsd_pkg::ROWS - 1)] ^= 1'b1;
            end
            levels = ~held_keys[col];
            if ($urandom_range(99) < 8) levels[$urandom_range(kpsd_pkg::ROWS - 1)] ^= 1'b1;
        end
        return levels;
    endfunction

    initial begin
        kpsd_pkg::t_cnt phase_limits[PHASES];
        int             idle_mode;
        phase_limits = '{3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd4, 3'd3, 3'd7};
        foreach (held_keys[c]) held_keys[c] = '0;
        i_rst_n           <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;
        row_if.valid      <= 1'b0;
        row_if.row_levels <= '1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all released, then all pressed long enough to trip every key at the reset limit
        repeat (kpsd_pkg::COLUMNS) send_scan(4'hF);
        repeat (3 * kpsd_pkg::COLUMNS) send_scan(4'h0);
        drain_scans();
        // limit lowered below the counters: pressed keys hold without a new press
        write_limit(3'd1);
        repeat (kpsd_pkg::COLUMNS) send_scan(4'h0);
        drain_scans();
        write_limit(3'd0);
        repeat (kpsd_pkg::COLUMNS) send_scan(4'h0);
        send_scan(4'hA);
        send_scan(4'h5);
        drain_scans();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_limit(phase_limits[ph]);
            idle_mode = ph % 4;
            send_idle_pct = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 36 : 0;
            key_stall_pct = (idle_mode == 2) ? 46 : (idle_mode == 3) ? 36 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) send_scan(next_levels(scan_col));
            drain_scans();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS keypad_scan_debounce_select_core");
        end else begin
            $display("FAIL keypad_scan_debounce_select_core");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/kpsd_pkg.sv
design/kpsd_if.sv
design/keypad_scan_debounce_select_core.sv
test/tb_keypad_scan_debounce_select_core.sv
